// ===== hw/rtl/fqds_pkg.sv =====
// Shared types, codes and helpers for the FIFO queue unit.
// No dependencies; every other file of the block imports this package.
package fqds_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_DUMP   = 2'd2;
    localparam logic [1:0] ACT_STATS  = 2'd3;

    localparam logic [1:0] KIND_LISTED  = 2'd0;
    localparam logic [1:0] KIND_REMOVED = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_STATS   = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               reply_kind;
        logic signed [DATA_W-1:0] item_out;
        logic                     last;
        logic [DATA_W-1:0]        solved_total;
        logic [CNT_W-1:0]         pending_total;
    } t_out_item;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       dump_load;
        logic       dump_step;
        logic       emit;
        logic       rd_dump;
        logic       last;
        logic [1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
    } t_status;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage

// ===== hw/rtl/fqds_ctrl.sv =====
// Controller state machine of the FIFO queue unit.
// Depends on fqds_pkg; drives commands to fqds_dpath from its status.
module fqds_ctrl
    import fqds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic [1:0] i_action,
    input  t_status  i_status,
    output t_cmd     o_cmd,
    output logic     busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_action)
                        ACT_ADD: begin
                            o_cmd.push = !i_status.full;
                        end
                        ACT_REMOVE: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            if (i_status.empty) begin
                                o_cmd.kind = KIND_EMPTY;
                            end else begin
                                o_cmd.kind = KIND_REMOVED;
                                o_cmd.pop  = 1'b1;
                            end
                        end
                        ACT_DUMP: begin
                            if (i_status.empty) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.last = 1'b1;
                                o_cmd.kind = KIND_EMPTY;
                            end else begin
                                o_cmd.dump_load = 1'b1;
                                n_state         = S_DUMP;
                            end
                        end
                        default: begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            o_cmd.kind = KIND_STATS;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                o_cmd.emit      = 1'b1;
                o_cmd.kind      = KIND_LISTED;
                o_cmd.rd_dump   = 1'b1;
                o_cmd.dump_step = 1'b1;
                o_cmd.last      = i_status.dump_last;
                if (i_status.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state == S_DUMP);

endmodule

// ===== hw/rtl/fqds_dpath.sv =====
// Datapath of the FIFO queue unit: ring memory, indexes, counters, result register.
// Depends on fqds_pkg; commanded by fqds_ctrl.
module fqds_dpath
    import fqds_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_status                  o_status,
    output logic                     o_strobe,
    output t_out_item                o_result
);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]  r_head, r_tail, r_pos;
    logic [CNT_W-1:0]  r_occ, r_left;
    logic [DATA_W-1:0] r_solved;
    logic              r_strobe;
    logic [1:0]        r_kind;
    logic [DATA_W-1:0] r_item;
    logic              r_last;
    logic [DATA_W-1:0] r_solved_out;
    logic [CNT_W-1:0]  r_pending_out;

    logic [IDX_W-1:0]  rd_addr;
    logic              rd_item;

    assign rd_addr = i_cmd.rd_dump ? r_pos : r_head;
    assign rd_item = (i_cmd.kind == KIND_LISTED) || (i_cmd.kind == KIND_REMOVED);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_value;
        end
        if (i_cmd.emit) begin
            r_item <= rd_item ? r_mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_solved <= '0;
            r_pos    <= '0;
            r_left   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_tail <= next_slot(r_tail);
                r_occ  <= r_occ + CNT_W'(1);
            end
            if (i_cmd.pop) begin
                r_head <= next_slot(r_head);
                r_occ  <= r_occ - CNT_W'(1);
                if (r_solved != '1) begin
                    r_solved <= r_solved + DATA_W'(1);
                end
            end
            if (i_cmd.dump_load) begin
                r_pos  <= r_head;
                r_left <= r_occ;
            end else if (i_cmd.dump_step) begin
                r_pos  <= next_slot(r_pos);
                r_left <= r_left - CNT_W'(1);
            end
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_kind        <= i_cmd.kind;
            r_last        <= i_cmd.last;
            r_solved_out  <= (i_cmd.kind == KIND_STATS) ? r_solved : '0;
            r_pending_out <= (i_cmd.kind == KIND_STATS) ? r_occ : '0;
        end
    end

    assign o_status.empty     = (r_occ == '0);
    assign o_status.full      = (r_occ == CNT_W'(QUEUE_DEPTH));
    assign o_status.dump_last = (r_left == CNT_W'(1));

    assign o_strobe                = r_strobe;
    assign o_result.reply_kind     = r_kind;
    assign o_result.item_out       = r_item;
    assign o_result.last           = r_last;
    assign o_result.solved_total   = r_solved_out;
    assign o_result.pending_total  = r_pending_out;

endmodule

// ===== hw/rtl/fifo_queue_with_dump_and_stats_unit.sv =====
// Top level of the FIFO queue unit with dump and statistics.
// Depends on fqds_pkg, fqds_ctrl and fqds_dpath.
//
// Usage:
//   Commands enter on i_item (action, item_value); a command transfers at a
//   rising edge with start high and busy low. Results leave on o_result, each
//   valid for one cycle while o_strobe is high; the receiver cannot stall.
//   Add: no result; dropped when the queue is full.
//   Remove and stats: the result shows in the cycle after the transfer.
//   Empty remove or dump: one empty reply, in the cycle after the transfer.
//   Dump of N queued items: N listed results; busy stays high while entries are
//   listed, one per cycle from the single read port of the ring memory, the
//   first one once the dump state has read and registered it. busy falls
//   in the cycle that carries the last listed entry, so the next command
//   may follow at once. The final result of every command has last set.
//   Reset (synchronous, active low) empties the queue, clears the solved
//   count and drops any dump in progress. Memory contents are not cleared.
module fifo_queue_with_dump_and_stats_unit
    import fqds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_cmd    cmd;
    t_status status;

    fqds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    fqds_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_item.item_value),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== hw/rtl/fqds_checker.sv =====
// Port-level checks for the FIFO queue unit, bound to the top level.
// Depends on fqds_pkg and fifo_queue_with_dump_and_stats_unit.
module fqds_checker
    import fqds_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_item  i_item,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_item.action == ACT_ADD) |=> !o_strobe)
        else $error("add produced a result");

    a_single_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && ((i_item.action == ACT_REMOVE) || (i_item.action == ACT_STATS))
        |=> o_strobe && o_result.last)
        else $error("remove or stats reply missing");

    a_more_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy && (o_result.reply_kind == KIND_LISTED))
        else $error("non-final result outside a dump");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.reply_kind == KIND_STATS)
        |-> o_result.pending_total <= CNT_W'(QUEUE_DEPTH))
        else $error("pending count above depth");

endmodule

bind fifo_queue_with_dump_and_stats_unit fqds_checker u_fqds_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
